// ===== rtl/sds_pkg.sv =====
package sds_pkg;

  localparam int MAX_SPRITES_DEF = 64;
  localparam int COORD_W         = 16;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int DIST_W          = SQ_W + 1;
  localparam int OIDX_W          = 6;
  localparam int ADDR_W          = 3;
  localparam int Q_DEPTH         = 4;

  localparam logic REG_VIEWER_X = 1'b0;
  localparam logic REG_VIEWER_Y = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] sprite_x;
    logic [COORD_W-1:0] sprite_y;
    logic               last_sprite;
  } sds_in_t;

  typedef struct packed {
    logic [OIDX_W-1:0] sprite_index;
    logic [DIST_W-1:0] squared_distance;
    logic              last_result;
    logic              overflow;
  } sds_out_t;

  // one word in the queue between front and sorter
  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [OIDX_W-1:0] idx;
    logic              store;
    logic              last;
    logic              ovf;
  } sds_q_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sds_qstat_t;

  typedef struct packed {
    logic done;
  } sds_bstat_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } sds_state_t;

endpackage

// ===== rtl/sds_front.sv =====
module sds_front #(
  parameter int MAX_SPRITES = sds_pkg::MAX_SPRITES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  sds_pkg::sds_in_t             item,
  input  logic [sds_pkg::COORD_W-1:0]  viewer_x,
  input  logic [sds_pkg::COORD_W-1:0]  viewer_y,
  output logic                         push,
  output sds_pkg::sds_q_t              push_data
);
  import sds_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPRITES + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;
  logic               store_now, ovf_now;

  logic               s0_vld_r;
  logic [COORD_W-1:0] s0_x_r, s0_y_r;
  logic [OIDX_W-1:0]  s0_idx_r;
  logic               s0_store_r, s0_last_r, s0_ovf_r;

  logic [COORD_W-1:0] dx, dy;
  logic               s1_vld_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [OIDX_W-1:0]  s1_idx_r;
  logic               s1_store_r, s1_last_r, s1_ovf_r;

  assign store_now = (cnt_r < CNT_W'(MAX_SPRITES));
  assign ovf_now   = drop_r | ~store_now;

  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (accept) begin
      if (item.last_sprite) begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end else begin
        if (store_now) cnt_nxt = cnt_r + CNT_W'(1);
        drop_nxt = ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      s0_vld_r <= accept;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_x_r     <= item.sprite_x;
      s0_y_r     <= item.sprite_y;
      s0_idx_r   <= OIDX_W'(cnt_r);
      s0_store_r <= store_now;
      s0_last_r  <= item.last_sprite;
      s0_ovf_r   <= ovf_now;
    end
  end

  assign dx = (s0_x_r >= viewer_x) ? s0_x_r - viewer_x : viewer_x - s0_x_r;
  assign dy = (s0_y_r >= viewer_y) ? s0_y_r - viewer_y : viewer_y - s0_y_r;

  always_ff @(posedge clk) begin
    if (s0_vld_r) begin
      sqx_r      <= SQ_W'(dx) * SQ_W'(dx);
      sqy_r      <= SQ_W'(dy) * SQ_W'(dy);
      s1_idx_r   <= s0_idx_r;
      s1_store_r <= s0_store_r;
      s1_last_r  <= s0_last_r;
      s1_ovf_r   <= s0_ovf_r;
    end
  end

  assign push              = s1_vld_r;
  assign push_data.sq_dist = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign push_data.idx     = s1_idx_r;
  assign push_data.store   = s1_store_r;
  assign push_data.last    = s1_last_r;
  assign push_data.ovf     = s1_ovf_r;

endmodule

// ===== rtl/sds_queue.sv =====
module sds_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sds_pkg::sds_q_t     push_data,
  input  logic                pop,
  output sds_pkg::sds_q_t     head,
  output sds_pkg::sds_qstat_t stat
);
  import sds_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  sds_q_t           mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head       = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= rd_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/sds_sorter.sv =====
module sds_sorter #(
  parameter int MAX_SPRITES = sds_pkg::MAX_SPRITES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sds_pkg::sds_q_t     head,
  input  sds_pkg::sds_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  output sds_pkg::sds_out_t   out_item,
  output sds_pkg::sds_bstat_t bstat
);
  import sds_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPRITES + 1);

  sds_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r;
  logic              ins, emit, done;
  logic [DIST_W-1:0] dist_r [MAX_SPRITES];
  logic [OIDX_W-1:0] idx_r  [MAX_SPRITES];
  logic [MAX_SPRITES-1:0] keep;
  logic              out_valid_r;
  sds_out_t          out_item_r;

  assign pop  = (state_r == ST_LOAD) & ~qstat.empty;
  assign ins  = pop & head.store;
  assign emit = (state_r == ST_EMIT);
  assign done = emit & (cnt_r == CNT_W'(1));

  assign bstat.done = done;

  // a cell holds its entry when it is at least as far as the newcomer
  always_comb begin
    for (int i = 0; i < MAX_SPRITES; i++) begin
      keep[i] = (CNT_W'(i) < cnt_r) && (dist_r[i] >= head.sq_dist);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        if (ins) cnt_nxt = cnt_r + CNT_W'(1);
        if (pop && head.last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (done) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) ovf_r <= head.ovf;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.sprite_index     <= idx_r[0];
      out_item_r.squared_distance <= dist_r[0];
      out_item_r.last_result      <= (cnt_r == CNT_W'(1));
      out_item_r.overflow         <= ovf_r;
    end
  end

  for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
    logic take_new;
    if (i == 0) begin : g_first
      assign take_new = 1'b1;
    end else begin : g_rest
      assign take_new = keep[i-1];
    end

    always_ff @(posedge clk) begin
      if (ins && !keep[i]) begin
        if (take_new) begin
          dist_r[i] <= head.sq_dist;
          idx_r[i]  <= head.idx;
        end else if (i > 0) begin
          dist_r[i] <= dist_r[(i > 0) ? i - 1 : 0];
          idx_r[i]  <= idx_r[(i > 0) ? i - 1 : 0];
        end
      end else if (emit && i < MAX_SPRITES - 1) begin
        // advance toward the head
        dist_r[i] <= dist_r[(i < MAX_SPRITES - 1) ? i + 1 : i];
        idx_r[i]  <= idx_r[(i < MAX_SPRITES - 1) ? i + 1 : i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/sprite_distance_sort.sv =====
// Sprite depth sorter: sprites load one per cycle; a set closes on last_sprite.
// Load: busy stays low, one sprite accepted every cycle through a 2-stage front and a queue.
// Output: once the last sprite has passed the front, the queue and the sorter's insert, results
// are registered out one per cycle, N results for N stored sprites, farthest first.
// busy rises with the last sprite and falls as the final result is driven.
// Reset (rst_n low, synchronous) clears counts, flags and the viewer registers.
module sprite_distance_sort #(
  parameter int MAX_SPRITES = sds_pkg::MAX_SPRITES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sds_pkg::sds_in_t            in_item,
  output logic                        out_valid,
  output sds_pkg::sds_out_t           out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sds_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sds_pkg::*;

  logic [COORD_W-1:0] viewer_x_r, viewer_y_r;
  logic               busy_r;
  logic               accept, cfg_wr;
  logic               push, pop;
  sds_q_t             push_data, head;
  sds_qstat_t         qstat;
  sds_bstat_t         bstat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewer_x_r <= '0;
      viewer_y_r <= '0;
      busy_r     <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_VIEWER_X) viewer_x_r <= pwdata[COORD_W-1:0];
      if (cfg_wr && paddr[2] == REG_VIEWER_Y) viewer_y_r <= pwdata[COORD_W-1:0];
      // hold busy from the closing sprite until the final result
      if (accept && in_item.last_sprite) busy_r <= 1'b1;
      else if (bstat.done) busy_r <= 1'b0;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VIEWER_Y) prdata[COORD_W-1:0] = viewer_y_r;
    else prdata[COORD_W-1:0] = viewer_x_r;
  end

  sds_front #(.MAX_SPRITES(MAX_SPRITES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .viewer_x  (viewer_x_r),
    .viewer_y  (viewer_y_r),
    .push      (push),
    .push_data (push_data)
  );

  sds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  sds_sorter #(.MAX_SPRITES(MAX_SPRITES)) u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .bstat     (bstat)
  );

endmodule

// ===== rtl/sds_checker.sv =====
module sds_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input sds_pkg::sds_in_t  in_item,
  input logic              out_valid,
  input sds_pkg::sds_out_t out_item,
  input logic              pready
);
  import sds_pkg::*;

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.last_sprite |=> busy)
    else $error("busy did not rise after closing sprite");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |-> busy)
    else $error("result outside a busy output run");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |=> out_valid)
    else $error("gap inside output run");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |=> !out_valid)
    else $error("result after final result of run");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind sprite_distance_sort sds_checker u_sds_checker (.*);
